FILE: rtl/prd_pkg.sv
// ---------------------------------------------------------------------------
// PCX RLE palette decoder package
// Shared widths, constants, command codes and controller types.
// ---------------------------------------------------------------------------
package prd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_DIM         = 1024;

  localparam int COLOR_W   = 8;
  localparam int IDX_W     = $clog2(PALETTE_ENTRIES);
  localparam int RGB_W     = 3 * COLOR_W;
  localparam int DIM_W     = 11;
  localparam int TOTAL_W   = 21;
  localparam int CNT_W     = 6;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = DIM_W;

  localparam logic [COLOR_W-1:0] RUN_MARK = 8'hC0;
  localparam logic [COLOR_W-1:0] RUN_MASK = 8'h3F;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_START = 2'd2
  } prd_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RLE    = 2'd2
  } prd_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } prd_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept_ok;
    logic emit_en;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_start;
    logic run_end;
  } ctl_sts_t;

endpackage

FILE: rtl/prd_in_if.sv
// ---------------------------------------------------------------------------
// PCX decoder input channel
// Valid/ready channel carrying palette loads, image bytes and image starts.
// ---------------------------------------------------------------------------
interface prd_in_if;
  logic                        valid;
  logic                        ready;
  logic [prd_pkg::CMD_W-1:0]   cmd;
  logic [prd_pkg::IDX_W-1:0]   palette_index;
  logic [prd_pkg::COLOR_W-1:0] red_in;
  logic [prd_pkg::COLOR_W-1:0] green_in;
  logic [prd_pkg::COLOR_W-1:0] blue_in;
  logic [prd_pkg::COLOR_W-1:0] data_byte;

  modport source (output valid, cmd, palette_index, red_in, green_in, blue_in, data_byte,
                  input ready);
  modport sink   (input valid, cmd, palette_index, red_in, green_in, blue_in, data_byte,
                  output ready);
endinterface

FILE: rtl/prd_out_if.sv
// ---------------------------------------------------------------------------
// PCX decoder pixel channel
// Valid/ready channel carrying one RGB pixel per item with run/image flags.
// ---------------------------------------------------------------------------
interface prd_out_if;
  logic                        valid;
  logic                        ready;
  logic [prd_pkg::COLOR_W-1:0] red;
  logic [prd_pkg::COLOR_W-1:0] green;
  logic [prd_pkg::COLOR_W-1:0] blue;
  logic                        run_last;
  logic                        image_last;

  modport source (output valid, red, green, blue, run_last, image_last, input ready);
  modport sink   (input valid, red, green, blue, run_last, image_last, output ready);
endinterface

FILE: rtl/prd_cfg_if.sv
// ---------------------------------------------------------------------------
// PCX decoder configuration channel
// Valid/ready register write channel: register index and write data.
// ---------------------------------------------------------------------------
interface prd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [prd_pkg::CFG_IDX_W-1:0] index;
  logic [prd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/prd_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module prd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/prd_ctrl.sv
// ---------------------------------------------------------------------------
// PCX decoder controller
// Two-state sequencer: take items while idle, emit a run's pixels while busy.
// ---------------------------------------------------------------------------
module prd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  prd_pkg::ctl_sts_t sts,
  output prd_pkg::ctl_cmd_t cmd
);

  prd_pkg::prd_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prd_pkg::ST_IDLE: begin
        if (sts.run_start) begin
          state_nxt = prd_pkg::ST_EMIT;
        end
      end
      prd_pkg::ST_EMIT: begin
        if (sts.run_end) begin
          state_nxt = prd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = prd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      prd_pkg::ST_IDLE: cmd.accept_ok = 1'b1;
      prd_pkg::ST_EMIT: cmd.emit_en   = 1'b1;
      default:          cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/prd_dp.sv
// ---------------------------------------------------------------------------
// PCX decoder datapath
// Config registers, run parser, palette RAM, pixel counter and output stage.
// ---------------------------------------------------------------------------
module prd_dp (
  input  logic              clk,
  input  logic              rst_n,
  prd_in_if.sink            in_ch,
  prd_out_if.source         out_ch,
  prd_cfg_if.sink           cfg_ch,
  input  prd_pkg::ctl_cmd_t cmd,
  output prd_pkg::ctl_sts_t sts
);

  localparam int DIM_W   = prd_pkg::DIM_W;
  localparam int TOTAL_W = prd_pkg::TOTAL_W;
  localparam int CNT_W   = prd_pkg::CNT_W;
  localparam int COLOR_W = prd_pkg::COLOR_W;
  localparam int RGB_W   = prd_pkg::RGB_W;

  // configuration registers
  logic [DIM_W-1:0]   width_r, height_r;
  logic               rle_r;
  // run state
  logic               awaiting_r;
  logic [CNT_W-1:0]   pending_r;
  logic [CNT_W-1:0]   rem_r;
  logic [TOTAL_W-1:0] emitted_r;
  logic [TOTAL_W-1:0] total_r;
  // output stage
  logic               out_valid_r;
  logic [RGB_W-1:0]   out_rgb_r;
  logic               out_run_last_r;
  logic               out_img_last_r;

  logic               cfg_wr;
  logic               acc;
  logic               is_data;
  logic [COLOR_W-1:0] mark_bits;
  logic [COLOR_W-1:0] mask_bits;
  logic               is_hdr;
  logic [CNT_W-1:0]   run_cnt;
  logic               run_start;
  logic [DIM_W-1:0]   w_c, h_c;
  logic [2*DIM_W-1:0] prod;
  logic [TOTAL_W-1:0] emitted_inc;
  logic               limit_hit;
  logic               slot_free;
  logic               last_img;
  logic               last_run;
  logic               fire;
  logic [RGB_W-1:0]   ram_rdata;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      rle_r    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        prd_pkg::REG_WIDTH:  width_r  <= cfg_ch.data;
        prd_pkg::REG_HEIGHT: height_r <= cfg_ch.data;
        prd_pkg::REG_RLE:    rle_r    <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // pixel limit, registered after the multiply
  assign w_c  = (width_r  > DIM_W'(prd_pkg::MAX_DIM)) ? DIM_W'(prd_pkg::MAX_DIM) : width_r;
  assign h_c  = (height_r > DIM_W'(prd_pkg::MAX_DIM)) ? DIM_W'(prd_pkg::MAX_DIM) : height_r;
  assign prod = {{DIM_W{1'b0}}, w_c} * {{DIM_W{1'b0}}, h_c};

  always_ff @(posedge clk) begin
    total_r <= prod[TOTAL_W-1:0];
  end

  // item decode
  assign in_ch.ready = cmd.accept_ok;
  assign acc         = in_ch.valid && cmd.accept_ok;
  assign is_data     = (in_ch.cmd == prd_pkg::CMD_DATA);
  assign mark_bits   = in_ch.data_byte & prd_pkg::RUN_MARK;
  assign mask_bits   = in_ch.data_byte & prd_pkg::RUN_MASK;
  assign is_hdr      = rle_r && !awaiting_r && (mark_bits == prd_pkg::RUN_MARK);
  assign run_cnt     = awaiting_r ? pending_r : CNT_W'(1);
  assign run_start   = acc && is_data && !is_hdr && (run_cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      pending_r  <= '0;
    end else if (acc) begin
      case (in_ch.cmd)
        prd_pkg::CMD_START: begin
          awaiting_r <= 1'b0;
          pending_r  <= '0;
        end
        prd_pkg::CMD_DATA: begin
          if (awaiting_r) begin
            awaiting_r <= 1'b0;
            pending_r  <= '0;
          end else if (is_hdr) begin
            awaiting_r <= 1'b1;
            pending_r  <= mask_bits[CNT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  prd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (prd_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (acc && (in_ch.cmd == prd_pkg::CMD_LOAD)),
    .waddr (in_ch.palette_index),
    .wdata ({in_ch.red_in, in_ch.green_in, in_ch.blue_in}),
    .re    (run_start),
    .raddr (in_ch.data_byte),
    .rdata (ram_rdata)
  );

  // pixel emission
  assign emitted_inc = emitted_r + TOTAL_W'(1);
  assign limit_hit   = (emitted_r >= total_r);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign last_img    = (emitted_inc == total_r);
  assign last_run    = (rem_r == CNT_W'(1)) || last_img;
  assign fire        = cmd.emit_en && !limit_hit && slot_free;

  assign sts.run_start = run_start;
  // stop on a full image as well as on the run's final pixel
  assign sts.run_end   = cmd.emit_en && (limit_hit || (slot_free && last_run));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emitted_r <= '0;
    end else if (acc && (in_ch.cmd == prd_pkg::CMD_START)) begin
      emitted_r <= '0;
    end else if (fire) begin
      emitted_r <= emitted_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (run_start) begin
      rem_r <= run_cnt;
    end else if (fire) begin
      rem_r <= rem_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rgb_r      <= ram_rdata;
      out_run_last_r <= last_run;
      out_img_last_r <= last_img;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red        = out_rgb_r[RGB_W-1 -: COLOR_W];
  assign out_ch.green      = out_rgb_r[COLOR_W +: COLOR_W];
  assign out_ch.blue       = out_rgb_r[COLOR_W-1:0];
  assign out_ch.run_last   = out_run_last_r;
  assign out_ch.image_last = out_img_last_r;

endmodule

FILE: rtl/pcx_rle_palette_decoder_core.sv
// Flow: palette loads, image starts and run headers are each taken without holding the
// input. A pixel byte reads the palette at its accepting edge; the read data passes the
// palette RAM's read register and then the output register. A run of N pixels then
// leaves one per cycle while the pixel side is ready. A byte that starts a run holds the
// input until its last pixel is sent or the image is full; other items do not hold it.
// Reset: synchronous, active low; run state, count, regs to 1x1 RLE on; palette kept.
// ---------------------------------------------------------------------------
// PCX RLE palette decoder
// Decodes PCX run-length bytes into palette-indexed RGB pixels.
// ---------------------------------------------------------------------------
module pcx_rle_palette_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  prd_in_if.sink     in_ch,
  prd_out_if.source  out_ch,
  prd_cfg_if.sink    cfg_ch
);

  prd_pkg::ctl_cmd_t ctl_cmd;
  prd_pkg::ctl_sts_t ctl_sts;

  prd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (ctl_sts),
    .cmd   (ctl_cmd)
  );

  prd_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (ctl_cmd),
    .sts    (ctl_sts)
  );

  // a started run makes the block busy on the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_sts.run_start |=> (ctl_cmd.emit_en && !in_ch.ready))
    else $error("run start did not enter emit");

  // the image's final pixel always closes its run
  a_img_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.image_last) |-> out_ch.run_last)
    else $error("image_last without run_last");

  // never take input while emitting
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !ctl_cmd.emit_en)
    else $error("input ready during emit");

endmodule
